### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the first expression holds, the second holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/etva_pkg.sv
package etva_pkg;

  localparam int RING_DEPTH    = 16;
  localparam int FRACTION_BITS = 8;

  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int VEL_W       = 40;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int LEN_W       = 5;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W   = VEL_W + RING_AW;

  localparam int MS_TO_US  = 1000;
  localparam int TIMEOUT_W = 26;
  localparam int VEL_SCALE = 1000000;
  localparam int SCALE_W   = 20;
  localparam int NUM_W     = COUNT_W + SCALE_W;

  localparam int DIV_RAW_W  = (NUM_W + FRACTION_BITS > SUM_W) ? NUM_W + FRACTION_BITS : SUM_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_W      = ((DIV_RAW_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  localparam int ZERO_TIMEOUT_RESET   = 50;
  localparam int AVERAGE_LENGTH_RESET = 4;
  localparam int MIN_LENGTH           = 2;

  localparam logic signed [VEL_W-1:0] V_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] V_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_TIMEOUT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_LENGTH = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    KIND_TIMEOUT,
    KIND_NO_MOVEMENT,
    KIND_ZERO_INTERVAL,
    KIND_ESTIMATE
  } step_kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [FILL_W-1:0] clamp_length(input logic [LEN_W-1:0] value);
    logic [31:0] wide;
    wide = 32'(value);
    if (wide < 32'(MIN_LENGTH)) begin
      wide = 32'(MIN_LENGTH);
    end else if (wide > 32'(RING_DEPTH)) begin
      wide = 32'(RING_DEPTH);
    end
    return wide[FILL_W-1:0];
  endfunction

endpackage

### sv/edge_time_velocity_averager.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    time_us, position_count
// out      source     out_valid / out_stall  velocity, step_kind
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A timeout, no-movement or zero-interval request goes straight to S_EMIT, which raises out_valid
// once the output register is free. A new estimate passes S_MUL, the shared divider, S_SAT,
// the ring sum, the divider again for the mean and S_EMIT; the divider takes two quotient
// bits per cycle and the sum one ring read per cycle.
// Reset is synchronous; the ring is tracked by a fill count, so no clearing pass is needed.
// A result waits in the output register under out_stall while the next request is accepted;
// a configuration write stalls a request offered in the same cycle.
`include "assert_macros.svh"

module edge_time_velocity_averager import etva_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [TIME_W-1:0]             time_us,
  input  logic signed [COUNT_W-1:0]     position_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VEL_W-1:0]       velocity,
  output logic [1:0]                    step_kind,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_VSTART,
    S_VWAIT,
    S_SAT,
    S_SUM,
    S_MSTART,
    S_MWAIT,
    S_EMIT
  } state_t;

  state_t                    state;
  logic [TIMEOUT_W-1:0]      timeout_us;
  logic [FILL_W-1:0]         eff_len;
  logic [TIME_W-1:0]         ref_time;
  logic [COUNT_W-1:0]        ref_count;
  logic signed [VEL_W-1:0]   held;
  logic [RING_AW-1:0]        wr_idx;
  logic [FILL_W-1:0]         fill;
  logic                      work_neg;
  logic [COUNT_W-1:0]        work_dmag;
  logic [TIME_W-1:0]         work_dt;
  logic [NUM_W-1:0]          num;
  logic [DIV_W:0]            qr;
  logic signed [SUM_W-1:0]   sum;
  logic [FILL_W-1:0]         rd_ptr;
  logic                      rd_pend;
  logic                      mean_neg;
  logic signed [VEL_W-1:0]   res_vel;
  step_kind_t                res_kind;

  logic [TIME_W-1:0]         elapsed;
  logic [COUNT_W-1:0]        delta;
  logic                      timed_out;
  logic                      in_accept;
  logic                      cfg_write;
  logic [FILL_W-1:0]         idx_inc;
  logic [RING_AW-1:0]        wr_idx_next;
  logic [FILL_W-1:0]         fill_next;
  logic                      push;
  logic signed [VEL_W-1:0]   sat_sample;
  logic [VEL_W-1:0]          ram_wdata;
  logic [VEL_W-1:0]          ram_rdata;
  logic [SUM_W-1:0]          mean_mag;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIVISOR_W-1:0]      div_divisor;
  div_status_t               div_status;
  logic [DIV_W-1:0]          div_quotient;
  logic [DIVISOR_W-1:0]      div_remainder;
  logic                      div_round;
  logic [VEL_W-1:0]          mean_q;

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    elapsed   = time_us - ref_time;
    delta     = COUNT_W'(position_count) - ref_count;
    timed_out = elapsed > TIME_W'(timeout_us);

    idx_inc     = FILL_W'(wr_idx) + FILL_W'(1);
    wr_idx_next = (idx_inc == eff_len) ? '0 : idx_inc[RING_AW-1:0];
    fill_next   = (fill < eff_len) ? fill + FILL_W'(1) : fill;

    if (work_neg) begin
      if (qr >= ((DIV_W+1)'(1) << (VEL_W - 1))) begin
        sat_sample = V_MIN;
      end else begin
        sat_sample = -$signed(qr[VEL_W-1:0]);
      end
    end else begin
      if (qr > (DIV_W+1)'(V_MAX)) begin
        sat_sample = V_MAX;
      end else begin
        sat_sample = $signed(qr[VEL_W-1:0]);
      end
    end

    push      = (in_accept && timed_out) || (state == S_SAT);
    ram_wdata = (state == S_SAT) ? sat_sample : '0;

    mean_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    div_start = (state == S_VSTART) || (state == S_MSTART);
    if ((state == S_MSTART) || (state == S_MWAIT)) begin
      div_dividend = DIV_W'(mean_mag);
      div_divisor  = DIVISOR_W'(fill);
    end else begin
      div_dividend = DIV_W'(num) << FRACTION_BITS;
      div_divisor  = work_dt;
    end

    div_round = {div_remainder, 1'b0} >= {1'b0, div_divisor};
    mean_q    = div_quotient[VEL_W-1:0] + VEL_W'(div_round);
  end

  etva_ram #(
    .WIDTH(VEL_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (push),
    .waddr(wr_idx),
    .wdata(ram_wdata),
    .raddr(rd_ptr[RING_AW-1:0]),
    .rdata(ram_rdata)
  );

  etva_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_status),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      timeout_us <= TIMEOUT_W'(ZERO_TIMEOUT_RESET * MS_TO_US);
      eff_len    <= clamp_length(LEN_W'(AVERAGE_LENGTH_RESET));
      ref_time   <= '0;
      ref_count  <= '0;
      held       <= '0;
      wr_idx     <= '0;
      fill       <= '0;
      rd_ptr     <= '0;
      rd_pend    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      if (push) begin
        wr_idx <= wr_idx_next;
        fill   <= fill_next;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (timed_out) begin
              held      <= '0;
              ref_time  <= time_us;
              ref_count <= COUNT_W'(position_count);
              res_vel   <= '0;
              res_kind  <= KIND_TIMEOUT;
              state     <= S_EMIT;
            end else if (delta == '0) begin
              res_vel  <= held;
              res_kind <= KIND_NO_MOVEMENT;
              state    <= S_EMIT;
            end else if (elapsed == '0) begin
              res_vel  <= held;
              res_kind <= KIND_ZERO_INTERVAL;
              state    <= S_EMIT;
            end else begin
              work_neg  <= delta[COUNT_W-1];
              work_dmag <= delta[COUNT_W-1] ? -delta : delta;
              work_dt   <= elapsed;
              ref_time  <= time_us;
              ref_count <= COUNT_W'(position_count);
              state     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          num   <= NUM_W'(work_dmag) * NUM_W'(VEL_SCALE);
          state <= S_VSTART;
        end
        S_VSTART: begin
          state <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_status.done) begin
            qr    <= (DIV_W+1)'(div_quotient) + (DIV_W+1)'(div_round);
            state <= S_SAT;
          end
        end
        S_SAT: begin
          sum     <= '0;
          rd_ptr  <= '0;
          rd_pend <= 1'b0;
          state   <= S_SUM;
        end
        S_SUM: begin
          if (rd_ptr < fill) begin
            rd_ptr <= rd_ptr + FILL_W'(1);
          end
          rd_pend <= (rd_ptr < fill);
          if (rd_pend) begin
            sum <= sum + SUM_W'($signed(ram_rdata));
          end
          if ((rd_ptr == fill) && !rd_pend) begin
            mean_neg <= sum[SUM_W-1];
            state    <= S_MSTART;
          end
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_status.done) begin
            held     <= mean_neg ? -$signed(mean_q) : $signed(mean_q);
            res_vel  <= mean_neg ? -$signed(mean_q) : $signed(mean_q);
            res_kind <= KIND_ESTIMATE;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            velocity  <= res_vel;
            step_kind <= res_kind;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_write) begin
        case (cfg_index)
          CFG_ZERO_TIMEOUT: begin
            timeout_us <= TIMEOUT_W'(cfg_data) * TIMEOUT_W'(MS_TO_US);
          end
          CFG_AVERAGE_LENGTH: begin
            eff_len <= clamp_length(cfg_data[LEN_W-1:0]);
            wr_idx  <= '0;
            fill    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_HOLDS(a_fill_bound, clk, rst, (fill <= eff_len) && (FILL_W'(wr_idx) < eff_len))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(velocity) && $stable(step_kind))

endmodule

### sv/etva_ram.sv
module etva_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/etva_divider.sv
`include "assert_macros.svh"

module etva_divider import etva_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_status_t          status,
  output logic [DIV_W-1:0]     quotient,
  output logic [DIVISOR_W-1:0] remainder
);

  logic [DIV_W-1:0]     dq;
  logic [DIV_W-1:0]     dq_next;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIV_CNT_W-1:0] cnt;

  always_comb begin
    logic [DIVISOR_W:0]   r_sh;
    logic [DIVISOR_W-1:0] r;
    logic [DIV_W-1:0]     d;
    logic                 qbit;
    r = rem;
    d = dq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r_sh = {r, d[DIV_W-1]};
      if (r_sh >= {1'b0, divisor_q}) begin
        r_sh = r_sh - {1'b0, divisor_q};
        qbit = 1'b1;
      end else begin
        qbit = 1'b0;
      end
      r = r_sh[DIVISOR_W-1:0];
      d = {d[DIV_W-2:0], qbit};
    end
    rem_next = r;
    dq_next  = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      if (start) begin
        dq          <= dividend;
        rem         <= '0;
        divisor_q   <= divisor;
        cnt         <= DIV_CNT_W'(DIV_CYCLES);
        status.busy <= 1'b1;
        status.done <= 1'b0;
      end else if (status.busy) begin
        dq          <= dq_next;
        rem         <= rem_next;
        cnt         <= cnt - 1'b1;
        status.busy <= (cnt != DIV_CNT_W'(1));
        status.done <= (cnt == DIV_CNT_W'(1));
      end else begin
        status.done <= 1'b0;
      end
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

  `ASSERT_HOLDS(a_start_when_free, clk, rst, !(start && status.busy))
  `ASSERT_NEXT(a_done_single, clk, rst, status.done, !status.done)
  `ASSERT_HOLDS(a_idle_count, clk, rst, status.busy || (cnt == '0))

endmodule

### sim/tb_edge_time_velocity_averager.sv
module tb_edge_time_velocity_averager import etva_pkg::*; ();

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int RANDOM_SEGMENTS = 18;
  localparam int SEGMENT_ITEMS   = 100;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    step_kind_t              kind;
  } velocity_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [TIME_W-1:0]         time_us = '0;
  logic signed [COUNT_W-1:0] position_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VEL_W-1:0]   velocity;
  logic [1:0]                step_kind;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  edge_time_velocity_averager dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .time_us(time_us),
    .position_count(position_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .velocity(velocity),
    .step_kind(step_kind),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [15:0]       timeout_ms_model;
  logic [LEN_W-1:0]  average_length_model;
  logic [31:0]       anchor_time;
  logic [31:0]       anchor_count;
  longint            held_rate;
  longint            ring_store [RING_DEPTH];
  int                ring_head;
  int                ring_fill;

  velocity_result_t  pending_results[$];
  int                kind_seen [4];
  int                mismatches = 0;
  int                results_checked = 0;
  int                requests_sent = 0;
  int                register_writes = 0;
  int                cycles_run = 0;
  int                receiver_hold = 0;
  bit                quiet_stretch = 1'b0;

  logic [31:0]       clock_us;
  logic [31:0]       position;

  task automatic clear_ring();
    int i;
    for (i = 0; i < RING_DEPTH; i++) begin
      ring_store[i] = 0;
    end
    ring_head = 0;
    ring_fill = 0;
  endtask

  task automatic push_ring(input longint sample);
    int span;
    span = int'(average_length_model);
    if (span < MIN_LENGTH) begin
      span = MIN_LENGTH;
    end
    if (span > RING_DEPTH) begin
      span = RING_DEPTH;
    end
    if (ring_head >= RING_DEPTH) begin
      ring_head = 0;
    end
    ring_store[ring_head] = sample;
    ring_head = (ring_head + 1) % span;
    if (ring_fill < span) begin
      ring_fill++;
    end
  endtask

  function automatic longint ring_average();
    longint      total;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    total = 0;
    if (ring_fill == 0) begin
      return 0;
    end
    for (i = 0; i < ring_fill; i++) begin
      total += ring_store[i];
    end
    mag = (total < 0) ? 64'(-total) : 64'(total);
    q = mag / 64'(ring_fill);
    r = mag % 64'(ring_fill);
    if (64'd2 * r >= 64'(ring_fill)) begin
      q++;
    end
    return (total < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Rate in ticks per second with FRACTION_BITS fraction bits, rounded half away
  // from zero on the magnitude and then saturated to the 40-bit signed range.
  function automatic longint instant_rate(input logic [31:0] delta, input logic [31:0] dt);
    logic [31:0] delta_mag;
    logic [63:0] dt_w;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] frac_num;
    logic [63:0] fq;
    logic [63:0] fr;
    logic [63:0] mag;
    delta_mag = delta[31] ? -delta : delta;
    dt_w = 64'(dt);
    num = 64'(delta_mag) * 64'd1000000;
    q = num / dt_w;
    r = num % dt_w;
    frac_num = r << FRACTION_BITS;
    fq = frac_num / dt_w;
    fr = frac_num % dt_w;
    if (64'd2 * fr >= dt_w) begin
      fq++;
    end
    if (q > ((64'd1 << VEL_W) >> FRACTION_BITS)) begin
      mag = 64'd1 << VEL_W;
    end else begin
      mag = (q << FRACTION_BITS) + fq;
    end
    if (delta[31]) begin
      return (mag > (64'd1 << (VEL_W - 1))) ? longint'(V_MIN) : -longint'(mag);
    end
    return (mag > 64'(V_MAX)) ? longint'(V_MAX) : longint'(mag);
  endfunction

  task automatic predict_velocity_step(input logic [TIME_W-1:0] now,
                                       input logic [COUNT_W-1:0] cnt);
    logic [31:0]      elapsed;
    logic [31:0]      delta;
    velocity_result_t res;
    elapsed = now - anchor_time;
    delta = cnt - anchor_count;
    if (elapsed > 32'(timeout_ms_model) * 32'd1000) begin
      held_rate = 0;
      push_ring(0);
      anchor_time = now;
      anchor_count = cnt;
      res.kind = KIND_TIMEOUT;
    end else if (delta == 0) begin
      res.kind = KIND_NO_MOVEMENT;
    end else if (elapsed == 0) begin
      res.kind = KIND_ZERO_INTERVAL;
    end else begin
      push_ring(instant_rate(delta, elapsed));
      held_rate = ring_average();
      anchor_time = now;
      anchor_count = cnt;
      res.kind = KIND_ESTIMATE;
    end
    res.velocity = VEL_W'(held_rate);
    kind_seen[res.kind]++;
    pending_results.push_back(res);
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s of result %0d: expected %0d, got %0d",
               field, results_checked, want, got);
    end
  endtask

  // The request stays valid after acceptance so that back-to-back requests need
  // no gap; callers that stop sending lower it through wait_for_results.
  task automatic send_request(input logic [TIME_W-1:0] t, input logic [COUNT_W-1:0] c);
    int gap;
    gap = 0;
    if (!quiet_stretch && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_us <= t;
    position_count <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_velocity_step(t, c);
    requests_sent++;
  endtask

  task automatic move(input logic [31:0] dt, input logic [31:0] dc);
    clock_us = clock_us + dt;
    position = position + dc;
    send_request(clock_us, position);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ZERO_TIMEOUT: timeout_ms_model = value;
      CFG_AVERAGE_LENGTH: begin
        average_length_model = value[LEN_W-1:0];
        clear_ring();
      end
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic test_directed_corners();
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'd7);
    send_request(32'd1, 32'h7FFF_FFFF);
    send_request(32'd2, 32'hFFFF_FFFF);
    send_request(32'd3, 32'h8000_0000);
    send_request(32'd50003, 32'h8000_0001);
    send_request(32'd100004, 32'h8000_0001);
    send_request(32'd100004, 32'd5);
    send_request(32'd100005, 32'd4);
    send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'd2, 32'h8000_0002);
    send_request(32'd9, 32'h8000_0004);
    clock_us = 32'd9;
    position = 32'h8000_0004;
  endtask

  task automatic test_timeout_limits();
    write_register(CFG_ZERO_TIMEOUT, 16'd0);
    move(32'd991, 32'd6);
    move(32'd0, 32'd0);
    move(32'd0, 32'd1);
    move(32'd1, 32'd1);
    write_register(CFG_ZERO_TIMEOUT, 16'hFFFF);
    move(32'd65535000, 32'd1);
    move(32'd65535001, 32'd1);
    write_register(CFG_ZERO_TIMEOUT, 16'(ZERO_TIMEOUT_RESET));
  endtask

  // The receiver is held off long enough for the output register and the core
  // to fill, so the sender sees the input stall while it keeps offering requests.
  task automatic test_output_backpressure();
    int k;
    receiver_hold = 400;
    for (k = 0; k < 40; k++) begin
      if (k % 2 == 1) begin
        move(32'd0, 32'd0);
      end else begin
        move(32'($urandom_range(1, 200)), 32'($urandom_range(1, 9)));
      end
    end
    wait_for_results();
  endtask

  task automatic test_random_motion();
    int                    seg;
    int                    k;
    int                    roll;
    logic [31:0]           limit_us;
    logic [31:0]           dt_cap;
    logic [31:0]           speed;
    logic [31:0]           dc;
    logic [CFG_DATA_W-1:0] tmo;
    logic [CFG_DATA_W-1:0] len;
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case ($urandom_range(0, 9))
        0: tmo = '0;
        1: tmo = '1;
        2, 3: tmo = CFG_DATA_W'($urandom_range(1, 5));
        default: tmo = CFG_DATA_W'($urandom_range(10, 300));
      endcase
      write_register(CFG_ZERO_TIMEOUT, tmo);
      case (seg)
        0: len = CFG_DATA_W'(2);
        1: len = CFG_DATA_W'(16);
        2: len = CFG_DATA_W'(0);
        3: len = CFG_DATA_W'(31);
        4: len = CFG_DATA_W'(1);
        5: len = CFG_DATA_W'(17);
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            len = CFG_DATA_W'($urandom_range(0, 31));
          end else begin
            len = CFG_DATA_W'($urandom_range(2, 16));
          end
        end
      endcase
      if (seg < 6 || $urandom_range(0, 1) == 1) begin
        write_register(CFG_AVERAGE_LENGTH, len);
      end
      quiet_stretch = (seg == RANDOM_SEGMENTS / 2);
      limit_us = 32'(tmo) * 32'd1000;
      dt_cap = ($urandom_range(0, 3) == 0) ? limit_us : 32'($urandom_range(1, 3000));
      if (dt_cap > limit_us) begin
        dt_cap = limit_us;
      end
      if (dt_cap == 0) begin
        dt_cap = 1;
      end
      case ($urandom_range(0, 3))
        0: speed = $urandom_range(1, 20);
        1: speed = $urandom_range(1, 5000);
        2: speed = $urandom_range(1, 2000000);
        default: speed = $urandom;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        speed = -speed;
      end
      for (k = 0; k < SEGMENT_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 66) begin
          dc = speed + 32'($urandom_range(0, 4)) - 32'd2;
          move(32'($urandom_range(1, dt_cap)), dc);
        end else if (roll < 74) begin
          move(32'($urandom_range(0, dt_cap)), 32'd0);
        end else if (roll < 80) begin
          dc = 32'($urandom_range(1, 50));
          move(32'd0, ($urandom_range(0, 1) == 1) ? -dc : dc);
        end else if (roll < 86) begin
          move(limit_us + 32'($urandom_range(1, 5000)), $urandom);
        end else begin
          clock_us = $urandom;
          position = $urandom;
          send_request(clock_us, position);
        end
      end
    end
    quiet_stretch = 1'b0;
  endtask

  always @(posedge clk) begin
    if (receiver_hold > 0) begin
      out_stall <= 1'b1;
      receiver_hold--;
    end else if (quiet_stretch) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk) begin : check_results
    velocity_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: velocity %0d, step_kind %0d", velocity, step_kind);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.velocity !== velocity) begin
          report_mismatch("velocity", longint'(want.velocity), longint'(velocity));
        end
        if (want.kind !== step_kind) begin
          report_mismatch("step_kind", longint'(want.kind), longint'(step_kind));
        end
        results_checked++;
      end
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("FAIL edge_time_velocity_averager");
    $finish;
  end

  initial begin
    timeout_ms_model = 16'(ZERO_TIMEOUT_RESET);
    average_length_model = LEN_W'(AVERAGE_LENGTH_RESET);
    anchor_time = '0;
    anchor_count = '0;
    held_rate = 0;
    clear_ring();
    clock_us = '0;
    position = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_timeout_limits();
    test_output_backpressure();
    test_random_motion();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += pending_results.size();

    $display("Covered %0d requests: %0d timeouts, %0d held without movement,",
             requests_sent, kind_seen[KIND_TIMEOUT], kind_seen[KIND_NO_MOVEMENT]);
    $display("%0d held at zero interval, %0d new estimates.",
             kind_seen[KIND_ZERO_INTERVAL], kind_seen[KIND_ESTIMATE]);
    $display("Checked %0d results across %0d register writes, %0d mismatches.",
             results_checked, register_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS edge_time_velocity_averager");
    end else begin
      $display("FAIL edge_time_velocity_averager");
    end
    $finish;
  end

endmodule
